// File: sv/erps_pkg.sv
// Shared types and constants for the elliptical ROI pixel statistics block.
package erps_pkg;

  localparam int VALUE_W  = 8;
  localparam int CENTER_W = 12;
  localparam int SEMI_W   = 11;
  localparam int COUNT_W  = 25;
  localparam int SUM_W    = 32;
  localparam int MEAN_W   = 16;
  localparam int FRAC_W   = 8;
  localparam int STEP_W   = $clog2(MEAN_W);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEMI_A   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEMI_B   = 2'd3;

  localparam int QUEUE_AW    = 3;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  typedef struct packed {
    logic               in_roi;
    logic [VALUE_W-1:0] value;
    logic               last;
  } entry_t;

  typedef enum logic [1:0] {
    BK_ACCUM,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

// File: sv/erps_ifs.sv
// Handshake interfaces for the pixel, configuration and statistics channels.
interface erps_pix_if #(parameter int COORD_WIDTH = 12);
  logic                            valid;
  logic                            ready;
  logic [COORD_WIDTH-1:0]          pixel_x;
  logic [COORD_WIDTH-1:0]          pixel_y;
  logic [erps_pkg::VALUE_W-1:0]    pixel_value;
  logic                            last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_value, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_value, last_pixel, output ready);
endinterface

interface erps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [erps_pkg::CFG_INDEX_W-1:0]  index;
  logic [erps_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface erps_stats_if;
  logic                          valid;
  logic                          ready;
  logic [erps_pkg::VALUE_W-1:0]  min_value;
  logic [erps_pkg::VALUE_W-1:0]  max_value;
  logic [erps_pkg::COUNT_W-1:0]  pixel_count;
  logic [erps_pkg::MEAN_W-1:0]   mean_value;
  logic                          region_empty;

  modport source (output valid, min_value, max_value, pixel_count, mean_value, region_empty,
                  input ready);
  modport sink   (input valid, min_value, max_value, pixel_count, mean_value, region_empty,
                  output ready);
endinterface

// File: sv/ellipse_roi_pixel_stats_core.sv
// Top level of the elliptical ROI pixel statistics block.
//
//   channel  dir  beat carries
//   pix      in   pixel_x, pixel_y, pixel_value, last_pixel
//   cfg      in   index, data (center_x, center_y, semi_a, semi_b)
//   stats    out  min_value, max_value, pixel_count, mean_value, region_empty
//
// One pixel per cycle, when there is room, enters a three-stage multiply pipeline
// for the ellipse test, then an 8-entry queue, then the accumulators, which drain one
// beat per cycle while accumulating. A window's last pixel sends the back end through
// prep and, for a non-empty region whose mean does not clamp, the serial mean divider.
// Reset (rst, synchronous) clears the registers, the accumulators and the queue.
// A stalled stats beat holds in the result register while the next window accumulates.
module ellipse_roi_pixel_stats_core #(
  parameter int COORD_WIDTH = 12
) (
  input  logic          clk,
  input  logic          rst,
  erps_pix_if.sink      pix,
  erps_cfg_if.sink      cfg,
  erps_stats_if.source  stats
);

  logic                           push;
  erps_pkg::entry_t               push_entry;
  logic                           pop;
  erps_pkg::entry_t               head;
  logic                           empty;
  logic [erps_pkg::QUEUE_CW-1:0]  queue_count;

  erps_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pix         (pix),
    .queue_count (queue_count),
    .push        (push),
    .entry       (push_entry)
  );

  erps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .count      (queue_count)
  );

  erps_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .stats (stats)
  );

endmodule

// File: sv/erps_front.sv
// Front end: configuration registers and the pipelined ellipse membership test.
module erps_front #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  erps_cfg_if.sink                        cfg,
  erps_pix_if.sink                        pix,
  input  logic [erps_pkg::QUEUE_CW-1:0]   queue_count,
  output logic                            push,
  output erps_pkg::entry_t                entry
);

  localparam int PW   = COORD_WIDTH + erps_pkg::SEMI_W;
  localparam int SQW  = 2 * PW;
  localparam int ABW  = 2 * erps_pkg::SEMI_W;
  localparam int AB2W = 4 * erps_pkg::SEMI_W;
  localparam int CMPW = (SQW + 1 > AB2W) ? SQW + 1 : AB2W;
  localparam int QUEUE_CW_T = erps_pkg::QUEUE_CW;

  logic [erps_pkg::CENTER_W-1:0] center_x;
  logic [erps_pkg::CENTER_W-1:0] center_y;
  logic [erps_pkg::SEMI_W-1:0]   semi_a;
  logic [erps_pkg::SEMI_W-1:0]   semi_b;

  logic [COORD_WIDTH-1:0] cx;
  logic [COORD_WIDTH-1:0] cy;
  logic [COORD_WIDTH-1:0] dx_next;
  logic [COORD_WIDTH-1:0] dy_next;
  logic                   accept;

  logic                           s1_valid;
  logic [COORD_WIDTH-1:0]         s1_dx;
  logic [COORD_WIDTH-1:0]         s1_dy;
  logic [erps_pkg::VALUE_W-1:0]   s1_value;
  logic                           s1_last;

  logic                           s2_valid;
  logic [PW-1:0]                  s2_p;
  logic [PW-1:0]                  s2_q;
  logic [ABW-1:0]                 s2_ab;
  logic                           s2_zero;
  logic [erps_pkg::VALUE_W-1:0]   s2_value;
  logic                           s2_last;

  logic                           s3_valid;
  logic [SQW-1:0]                 s3_p2;
  logic [SQW-1:0]                 s3_q2;
  logic [AB2W-1:0]                s3_ab2;
  logic                           s3_zero;
  logic [erps_pkg::VALUE_W-1:0]   s3_value;
  logic                           s3_last;

  logic [SQW-1:0]      p_sq;
  logic [SQW-1:0]      q_sq;
  logic [AB2W-1:0]     ab_sq;
  logic [SQW:0]        ell_lhs;
  logic [QUEUE_CW_T:0] occupancy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      semi_a   <= '0;
      semi_b   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        erps_pkg::REG_CENTER_X: center_x <= cfg.data;
        erps_pkg::REG_CENTER_Y: center_y <= cfg.data;
        erps_pkg::REG_SEMI_A:   semi_a   <= cfg.data[erps_pkg::SEMI_W-1:0];
        erps_pkg::REG_SEMI_B:   semi_b   <= cfg.data[erps_pkg::SEMI_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a pixel only if the queue can hold it and everything already in flight.
  assign occupancy = (QUEUE_CW_T+1)'(queue_count) + (QUEUE_CW_T+1)'(s1_valid)
                   + (QUEUE_CW_T+1)'(s2_valid) + (QUEUE_CW_T+1)'(s3_valid);
  assign pix.ready = occupancy < (QUEUE_CW_T+1)'(erps_pkg::QUEUE_DEPTH);
  assign accept    = pix.valid && pix.ready;

  assign cx      = COORD_WIDTH'(center_x);
  assign cy      = COORD_WIDTH'(center_y);
  assign dx_next = (pix.pixel_x >= cx) ? pix.pixel_x - cx : cx - pix.pixel_x;
  assign dy_next = (pix.pixel_y >= cy) ? pix.pixel_y - cy : cy - pix.pixel_y;

  assign p_sq  = SQW'(s2_p) * SQW'(s2_p);
  assign q_sq  = SQW'(s2_q) * SQW'(s2_q);
  assign ab_sq = AB2W'(s2_ab) * AB2W'(s2_ab);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx    <= dx_next;
    s1_dy    <= dy_next;
    s1_value <= pix.pixel_value;
    s1_last  <= pix.last_pixel;

    s2_p     <= PW'(s1_dx) * PW'(semi_b);
    s2_q     <= PW'(s1_dy) * PW'(semi_a);
    s2_ab    <= ABW'(semi_a) * ABW'(semi_b);
    s2_zero  <= (semi_a == '0) || (semi_b == '0);
    s2_value <= s1_value;
    s2_last  <= s1_last;

    s3_p2    <= p_sq;
    s3_q2    <= q_sq;
    s3_ab2   <= ab_sq;
    s3_zero  <= s2_zero;
    s3_value <= s2_value;
    s3_last  <= s2_last;
  end

  assign ell_lhs      = {1'b0, s3_p2} + {1'b0, s3_q2};
  assign push         = s3_valid;
  assign entry.in_roi = !s3_zero && (CMPW'(ell_lhs) <= CMPW'(s3_ab2));
  assign entry.value  = s3_value;
  assign entry.last   = s3_last;

endmodule

// File: sv/erps_queue.sv
// Short first-word-fall-through queue between the membership test and the accumulators.
module erps_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  erps_pkg::entry_t               push_entry,
  input  logic                           pop,
  output erps_pkg::entry_t               head,
  output logic                           empty,
  output logic [erps_pkg::QUEUE_CW-1:0]  count
);

  erps_pkg::entry_t                mem [erps_pkg::QUEUE_DEPTH];
  logic [erps_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [erps_pkg::QUEUE_AW-1:0]   rd_ptr;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/erps_back.sv
// Back end: running min/max/sum/count, serial mean divider and result register.
module erps_back (
  input  logic              clk,
  input  logic              rst,
  input  erps_pkg::entry_t  head,
  input  logic              empty,
  output logic              pop,
  erps_stats_if.source      stats
);

  localparam int VW = erps_pkg::VALUE_W;
  localparam int CW = erps_pkg::COUNT_W;
  localparam int SW = erps_pkg::SUM_W;
  localparam int MW = erps_pkg::MEAN_W;
  localparam int FW = erps_pkg::FRAC_W;

  erps_pkg::back_state_t state;
  erps_pkg::back_state_t state_next;

  logic [SW-1:0] intensity_sum;
  logic [CW-1:0] inside_count;
  logic [VW-1:0] running_min;
  logic [VW-1:0] running_max;

  logic [CW-1:0]                 rem;
  logic [MW-1:0]                 quot;
  logic [erps_pkg::STEP_W-1:0]   step;
  logic                          clamp;

  logic          out_valid;
  logic [VW-1:0] out_min;
  logic [VW-1:0] out_max;
  logic [CW-1:0] out_count;
  logic [MW-1:0] out_mean;
  logic          out_empty;

  logic          load_out;
  logic          clamp_now;
  logic [SW:0]   sum_add;
  logic [CW:0]   rem_shift;
  logic          geq;
  logic [CW:0]   rem_sub;
  logic [MW-1:0] mean_final;

  // Quotient overflows 16 bits exactly when sum >= count * 256.
  assign clamp_now = {1'b0, intensity_sum} >= {inside_count, {FW{1'b0}}};
  assign sum_add   = {1'b0, intensity_sum} + (SW+1)'(head.value);
  assign rem_shift = {rem, quot[MW-1]};
  assign geq       = rem_shift >= {1'b0, inside_count};
  assign rem_sub   = rem_shift - {1'b0, inside_count};

  always_comb begin
    if (inside_count == '0) begin
      mean_final = '0;
    end else if (clamp) begin
      mean_final = '1;
    end else begin
      mean_final = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erps_pkg::BK_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      erps_pkg::BK_ACCUM: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.last) begin
            state_next = erps_pkg::BK_PREP;
          end
        end
      end
      erps_pkg::BK_PREP: begin
        if (inside_count == '0 || clamp_now) begin
          state_next = erps_pkg::BK_DONE;
        end else begin
          state_next = erps_pkg::BK_DIV;
        end
      end
      erps_pkg::BK_DIV: begin
        if (step == erps_pkg::STEP_W'(MW - 1)) begin
          state_next = erps_pkg::BK_DONE;
        end
      end
      erps_pkg::BK_DONE: begin
        if (!out_valid || stats.ready) begin
          load_out   = 1'b1;
          state_next = erps_pkg::BK_ACCUM;
        end
      end
      default: state_next = erps_pkg::BK_ACCUM;
    endcase
  end

  // Accumulators: saturate sum and count, clear once the result is handed off.
  always_ff @(posedge clk) begin
    if (rst || load_out) begin
      intensity_sum <= '0;
      inside_count  <= '0;
      running_min   <= '1;
      running_max   <= '0;
    end else if (pop && head.in_roi) begin
      if (head.value < running_min) begin
        running_min <= head.value;
      end
      if (head.value > running_max) begin
        running_max <= head.value;
      end
      intensity_sum <= sum_add[SW] ? '1 : sum_add[SW-1:0];
      if (inside_count != '1) begin
        inside_count <= inside_count + 1'b1;
      end
    end
  end

  // Restoring divide of (sum << 8) by count, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (state == erps_pkg::BK_PREP) begin
      rem   <= CW'(intensity_sum[SW-1:FW]);
      quot  <= {intensity_sum[FW-1:0], {(MW-FW){1'b0}}};
      step  <= '0;
      clamp <= clamp_now;
    end else if (state == erps_pkg::BK_DIV) begin
      rem  <= geq ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
      quot <= {quot[MW-2:0], geq};
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (stats.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_min   <= running_min;
      out_max   <= running_max;
      out_count <= inside_count;
      out_mean  <= mean_final;
      out_empty <= (inside_count == '0);
    end
  end

  assign stats.valid        = out_valid;
  assign stats.min_value    = out_min;
  assign stats.max_value    = out_max;
  assign stats.pixel_count  = out_count;
  assign stats.mean_value   = out_mean;
  assign stats.region_empty = out_empty;

endmodule

// File: tb/sv/ellipse_roi_pixel_stats_core_test.sv
// Self-checking testbench for the elliptical ROI pixel statistics core.
`timescale 1ns / 100ps

module ellipse_roi_pixel_stats_core_test;

  localparam int COORD_W      = 12;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int DRAIN_CYCLES = 48;
  localparam int RANDOM_ITEMS = 1400;
  localparam int VALUE_W      = erps_pkg::VALUE_W;
  localparam int COUNT_W      = erps_pkg::COUNT_W;
  localparam int MEAN_W       = erps_pkg::MEAN_W;
  localparam int FRAC_W       = erps_pkg::FRAC_W;
  localparam int CENTER_W     = erps_pkg::CENTER_W;
  localparam int SEMI_W       = erps_pkg::SEMI_W;
  localparam int CFG_INDEX_W  = erps_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W   = erps_pkg::CFG_DATA_W;
  localparam longint unsigned SUM_SAT   = 64'hFFFF_FFFF;
  localparam longint unsigned COUNT_SAT = (64'd1 << COUNT_W) - 1;

  typedef struct {
    bit [VALUE_W-1:0] min_value;
    bit [VALUE_W-1:0] max_value;
    bit [COUNT_W-1:0] pixel_count;
    bit [MEAN_W-1:0]  mean_value;
    bit               region_empty;
  } stats_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  erps_pix_if #(.COORD_WIDTH(COORD_W)) pix_bus ();
  erps_cfg_if                          cfg_bus ();
  erps_stats_if                        stats_bus ();

  ellipse_roi_pixel_stats_core #(.COORD_WIDTH(COORD_W)) u_top (
    .clk   (clk),
    .rst   (rst),
    .pix   (pix_bus),
    .cfg   (cfg_bus),
    .stats (stats_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow registers and accumulators of the predictor
  bit [CENTER_W-1:0] ctr_x, ctr_y;
  bit [SEMI_W-1:0]   axis_a, axis_b;
  longint unsigned   sum_acc, count_acc;
  bit [VALUE_W-1:0]  min_acc, max_acc;

  stats_beat_t stats_expected[$];

  int errors          = 0;
  int pixels_sent     = 0;
  int windows_closed  = 0;
  int results_checked = 0;
  int empty_results   = 0;
  int settings_count  = 0;
  int burst_left      = 0;
  bit gaps_on         = 1'b1;
  int stall_mode      = 0;
  int stall_left      = 0;

  function automatic void clear_window();
    sum_acc   = 0;
    count_acc = 0;
    min_acc   = 8'hFF;
    max_acc   = 8'h00;
  endfunction

  function automatic bit roi_contains(bit [COORD_W-1:0] px, bit [COORD_W-1:0] py);
    longint unsigned dx, dy, a2, b2;
    if (axis_a == 0 || axis_b == 0) return 1'b0;
    dx = (px >= ctr_x) ? longint'(px - ctr_x) : longint'(ctr_x - px);
    dy = (py >= ctr_y) ? longint'(py - ctr_y) : longint'(ctr_y - py);
    a2 = longint'(axis_a) * longint'(axis_a);
    b2 = longint'(axis_b) * longint'(axis_b);
    return dx * dx * b2 + dy * dy * a2 <= a2 * b2;
  endfunction

  // Fold one accepted pixel into the window; close the window on the last one
  function automatic void accumulate_pixel(bit [COORD_W-1:0] px, bit [COORD_W-1:0] py,
                                           bit [VALUE_W-1:0] v, bit is_last);
    stats_beat_t beat;
    longint unsigned mean;
    if (roi_contains(px, py)) begin
      if (v < min_acc) min_acc = v;
      if (v > max_acc) max_acc = v;
      sum_acc = sum_acc + v;
      if (sum_acc > SUM_SAT) sum_acc = SUM_SAT;
      if (count_acc < COUNT_SAT) count_acc++;
    end
    if (!is_last) return;
    if (count_acc == 0) begin
      beat.min_value    = 8'hFF;
      beat.max_value    = 8'h00;
      beat.pixel_count  = '0;
      beat.mean_value   = '0;
      beat.region_empty = 1'b1;
    end else begin
      mean = (sum_acc << FRAC_W) / count_acc;
      if (mean > 64'hFFFF) mean = 64'hFFFF;
      beat.min_value    = min_acc;
      beat.max_value    = max_acc;
      beat.pixel_count  = count_acc[COUNT_W-1:0];
      beat.mean_value   = mean[MEAN_W-1:0];
      beat.region_empty = 1'b0;
    end
    stats_expected.insert(stats_expected.size(), beat);
    windows_closed++;
    clear_window();
  endfunction

  function automatic int clip_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int pick_center();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return COORD_MAX;
      2: return $urandom_range(0, 3);
      3: return $urandom_range(COORD_MAX - 3, COORD_MAX);
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // Hold valid until the core takes the beat; open a random gap between bursts
  task automatic send_pixel(input int px, input int py, input int v, input bit is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        pix_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel_x     <= COORD_W'(px);
    pix_bus.pixel_y     <= COORD_W'(py);
    pix_bus.pixel_value <= VALUE_W'(v);
    pix_bus.last_pixel  <= is_last;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    accumulate_pixel(COORD_W'(px), COORD_W'(py), VALUE_W'(v), is_last);
    pixels_sent++;
  endtask

  task automatic wait_drain();
    pix_bus.valid <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk);
    // let pixels that close no window clear the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input bit [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      erps_pkg::REG_CENTER_X: ctr_x  = d;
      erps_pkg::REG_CENTER_Y: ctr_y  = d;
      erps_pkg::REG_SEMI_A:   axis_a = d[SEMI_W-1:0];
      erps_pkg::REG_SEMI_B:   axis_b = d[SEMI_W-1:0];
      default: ;
    endcase
  endtask

  // Write the registers selected by sel once the core has gone idle
  task automatic write_config(input bit [3:0] sel, input int cx, input int cy,
                              input int sa, input int sb);
    wait_drain();
    if (sel[0]) put_reg(erps_pkg::REG_CENTER_X, CFG_DATA_W'(cx));
    if (sel[1]) put_reg(erps_pkg::REG_CENTER_Y, CFG_DATA_W'(cy));
    if (sel[2]) put_reg(erps_pkg::REG_SEMI_A, CFG_DATA_W'(sa));
    if (sel[3]) put_reg(erps_pkg::REG_SEMI_B, CFG_DATA_W'(sb));
    cfg_bus.valid <= 1'b0;
    settings_count++;
  endtask

  // Raster the bounding box plus a one-pixel margin, optionally cut short
  task automatic scan_window(input bit truncated);
    int x0, x1, y0, y1, w, total, stop_at, flat_v;
    bit flat;
    x0 = clip_coord(int'(ctr_x) - int'(axis_a) - 1);
    x1 = clip_coord(int'(ctr_x) + int'(axis_a) + 1);
    y0 = clip_coord(int'(ctr_y) - int'(axis_b) - 1);
    y1 = clip_coord(int'(ctr_y) + int'(axis_b) + 1);
    w = x1 - x0 + 1;
    total = w * (y1 - y0 + 1);
    stop_at = truncated ? $urandom_range(0, total - 1) : total - 1;
    flat = ($urandom_range(0, 7) == 0);
    flat_v = $urandom_range(0, 255);
    for (int n = 0; n <= stop_at; n++)
      send_pixel(x0 + n % w, y0 + n / w, flat ? flat_v : $urandom_range(0, 255), n == stop_at);
  endtask

  // Scatter points mostly around the ellipse, some anywhere in the frame
  task automatic sample_window(input int len);
    int px, py, ra, rb;
    ra = int'(axis_a) + 1;
    rb = int'(axis_b) + 1;
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        px = clip_coord(int'(ctr_x) + int'($urandom_range(0, 2 * ra)) - ra);
        py = clip_coord(int'(ctr_y) + int'($urandom_range(0, 2 * rb)) - rb);
      end else begin
        px = $urandom_range(0, COORD_MAX);
        py = $urandom_range(0, COORD_MAX);
      end
      send_pixel(px, py, $urandom_range(0, 255), n == len - 1);
    end
  endtask

  task automatic test_zero_axis();
    // registers still hold their reset values: both axes zero
    send_pixel(0, 0, 7, 1'b1);
    write_config(4'hF, 40, 40, 5, 0);
    send_pixel(40, 40, 200, 1'b0);
    send_pixel(41, 40, 3, 1'b1);
    write_config(4'hC, 0, 0, 0, 5);
    send_pixel(40, 40, 9, 1'b1);
  endtask

  task automatic test_boundary();
    write_config(4'hF, 100, 200, 3, 2);
    send_pixel(100, 200, 255, 1'b0);
    send_pixel(103, 200, 0, 1'b0);
    send_pixel(104, 200, 9, 1'b0);
    send_pixel(100, 202, 128, 1'b0);
    send_pixel(101, 202, 77, 1'b0);
    send_pixel(97, 198, 1, 1'b1);
  endtask

  task automatic test_extremes();
    // bit 11 of the semi-axis data is dropped by the register
    write_config(4'hF, COORD_MAX, COORD_MAX, 4095, 4095);
    send_pixel(0, 0, 5, 1'b0);
    send_pixel(2048, COORD_MAX, 255, 1'b0);
    send_pixel(COORD_MAX, 2048, 0, 1'b0);
    send_pixel(COORD_MAX, COORD_MAX, 17, 1'b0);
    send_pixel(2047, COORD_MAX, 99, 1'b1);
    write_config(4'h3, 0, 0, 0, 0);
    send_pixel(2047, 0, 1, 1'b0);
    send_pixel(0, 2047, 254, 1'b0);
    send_pixel(2048, 0, 66, 1'b0);
    send_pixel(COORD_MAX, COORD_MAX, 3, 1'b1);
  endtask

  task automatic test_mid_window_config();
    write_config(4'hF, 50, 50, 4, 4);
    send_pixel(50, 50, 10, 1'b0);
    send_pixel(54, 50, 20, 1'b0);
    send_pixel(60, 60, 30, 1'b0);
    // move the ellipse with the window still open; accumulators carry over
    write_config(4'h3, 60, 60, 0, 0);
    send_pixel(60, 60, 40, 1'b0);
    send_pixel(50, 50, 50, 1'b1);
  endtask

  task automatic test_random_windows();
    int stop_count, kind, windows, sa, sb;
    bit [3:0] sel;
    stop_count = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < stop_count) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          sa = ($urandom_range(0, 1) != 0) ? 4095 : int'($urandom_range(1, 4095));
          sb = ($urandom_range(0, 1) != 0) ? 2047 : int'($urandom_range(1, 4095));
        end
        1: begin
          sa = $urandom_range(0, 3);
          sb = $urandom_range(0, 3);
          if ($urandom_range(0, 1) != 0) sa = 2048 * int'($urandom_range(0, 1));
          else sb = 2048 * int'($urandom_range(0, 1));
        end
        default: begin
          sa = 2048 * int'($urandom_range(0, 1)) + int'($urandom_range(1, 3));
          sb = 2048 * int'($urandom_range(0, 1)) + int'($urandom_range(1, 3));
        end
      endcase
      sel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
      write_config(sel, pick_center(), pick_center(), sa, sb);
      gaps_on = ($urandom_range(0, 3) != 0);
      windows = $urandom_range(3, 6);
      for (int k = 0; k < windows && pixels_sent < stop_count; k++) begin
        if (axis_a <= 3 && axis_b <= 3) begin
          case ($urandom_range(0, 19))
            0, 1, 2:    scan_window(1'b1);
            3, 4, 5, 6: sample_window($urandom_range(1, 24));
            default:    scan_window(1'b0);
          endcase
        end else begin
          sample_window($urandom_range(1, 24));
        end
      end
    end
  endtask

  task automatic report_field(input string name, input longint unsigned want,
                              input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: pick a new random stall behavior whenever the current one runs out
  always @(posedge clk) begin
    if (rst) begin
      stats_bus.ready <= 1'b1;
      stall_left      <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(16, 64);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: stats_bus.ready <= 1'b1;
        1: stats_bus.ready <= ($urandom_range(0, 1) != 0);
        2: stats_bus.ready <= ($urandom_range(0, 3) == 0);
        default: stats_bus.ready <= (stall_left % 16) >= 10;
      endcase
    end
  end

  always @(posedge clk) begin : check_stats
    stats_beat_t want;
    if (!rst && stats_bus.valid && stats_bus.ready) begin
      if (stats_expected.size() == 0) begin
        errors++;
        $display("%0t ns: stats beat with nothing expected, got min %0d max %0d count %0d",
                 $time, stats_bus.min_value, stats_bus.max_value, stats_bus.pixel_count);
      end else begin
        want = stats_expected.pop_front();
        report_field("min_value", want.min_value, stats_bus.min_value);
        report_field("max_value", want.max_value, stats_bus.max_value);
        report_field("pixel_count", want.pixel_count, stats_bus.pixel_count);
        report_field("mean_value", want.mean_value, stats_bus.mean_value);
        report_field("region_empty", want.region_empty, stats_bus.region_empty);
        results_checked++;
        if (want.region_empty) empty_results++;
      end
    end
  end

  initial begin
    pix_bus.valid       <= 1'b0;
    pix_bus.pixel_x     <= '0;
    pix_bus.pixel_y     <= '0;
    pix_bus.pixel_value <= '0;
    pix_bus.last_pixel  <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= erps_pkg::REG_CENTER_X;
    cfg_bus.data        <= '0;
    ctr_x  = '0;
    ctr_y  = '0;
    axis_a = '0;
    axis_b = '0;
    clear_window();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_axis();
    test_boundary();
    test_extremes();
    test_mid_window_config();
    test_random_windows();
    wait_drain();

    $display("Covered %0d pixels in %0d windows over %0d register settings",
             pixels_sent, windows_closed, settings_count);
    $display("Checked %0d statistics beats, %0d of them for an empty region",
             results_checked, empty_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: ellipse_roi_pixel_stats_core.f
sv/erps_pkg.sv
sv/erps_ifs.sv
sv/erps_front.sv
sv/erps_queue.sv
sv/erps_back.sv
sv/ellipse_roi_pixel_stats_core.sv
tb/sv/ellipse_roi_pixel_stats_core_test.sv
